[rtl/strided_dma_chunk_generator_macros.svh]
// Assertion helpers shared by the RTL files.
`ifndef STRIDED_DMA_CHUNK_GENERATOR_MACROS_SVH
`define STRIDED_DMA_CHUNK_GENERATOR_MACROS_SVH

// Checked only while out of reset.
`define SDCG_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Checked at every edge, reset included.
`define SDCG_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[rtl/sdcg_pkg.sv]
package sdcg_pkg;

    localparam int DEF_ADDR_WIDTH     = 32;
    localparam int DEF_MAX_FLIT_BYTES = 64;

    localparam int OP_W      = 2;
    localparam int ROW_W     = 16;
    localparam int STRIDE_W  = 32;
    localparam int COUNT_W   = 8;
    localparam int FLIT_CFG_W = 7;
    localparam int STATUS_W  = 4;
    localparam int KIND_W    = 2;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [FLIT_CFG_W-1:0] FLIT_RESET     = 7'd64;
    localparam logic [COUNT_W-1:0]    INFLIGHT_RESET = 8'd16;
    localparam logic [COUNT_W-1:0]    SETUP_RESET    = 8'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FLIT_BYTES   = 2'd0,
        CFG_MAX_INFLIGHT = 2'd1,
        CFG_SETUP_STEPS  = 2'd2,
        CFG_UNUSED       = 2'd3
    } t_cfg_idx;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD = 2'd0,
        OP_STEP = 2'd1,
        OP_DONE = 2'd2,
        OP_RSVD = 2'd3
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_LOADED    = 4'd0,
        ST_CHUNK     = 4'd1,
        ST_SETUP     = 4'd2,
        ST_STALL     = 4'd3,
        ST_IDLE      = 4'd4,
        ST_EMPTY     = 4'd5,
        ST_NO_LOCAL  = 4'd6,
        ST_DONE_OK   = 4'd7,
        ST_UNDERFLOW = 4'd8,
        ST_BUSY      = 4'd9
    } t_status;

    typedef enum logic [KIND_W-1:0] {
        KIND_LOCAL = 2'd0,
        KIND_PUSH  = 2'd1,
        KIND_PULL  = 2'd2
    } t_kind;

endpackage

[rtl/sdcg_ifs.sv]
interface sdcg_in_if #(
    parameter int ADDR_WIDTH = sdcg_pkg::DEF_ADDR_WIDTH
);
    logic                                valid;
    logic                                ready;
    logic [sdcg_pkg::OP_W-1:0]           op;
    logic [ADDR_WIDTH-1:0]               src_base;
    logic [ADDR_WIDTH-1:0]               dst_base;
    logic [sdcg_pkg::ROW_W-1:0]          row_count;
    logic [sdcg_pkg::ROW_W-1:0]          row_length;
    logic signed [sdcg_pkg::STRIDE_W-1:0] src_step;
    logic signed [sdcg_pkg::STRIDE_W-1:0] dst_step;
    logic                                src_in_dram;
    logic                                dst_in_dram;
    logic                                src_is_own;
    logic                                dst_is_own;

    modport source (
        output valid, op, src_base, dst_base, row_count, row_length, src_step, dst_step,
               src_in_dram, dst_in_dram, src_is_own, dst_is_own,
        input  ready
    );
    modport sink (
        input  valid, op, src_base, dst_base, row_count, row_length, src_step, dst_step,
               src_in_dram, dst_in_dram, src_is_own, dst_is_own,
        output ready
    );
endinterface

interface sdcg_out_if #(
    parameter int ADDR_WIDTH = sdcg_pkg::DEF_ADDR_WIDTH,
    parameter int LEN_W      = 7
);
    logic                            valid;
    logic                            ready;
    logic [sdcg_pkg::STATUS_W-1:0]   status;
    logic [sdcg_pkg::KIND_W-1:0]     chunk_kind;
    logic [ADDR_WIDTH-1:0]           chunk_src;
    logic [ADDR_WIDTH-1:0]           chunk_dst;
    logic [LEN_W-1:0]                chunk_len;
    logic                            last_chunk;
    logic [sdcg_pkg::COUNT_W-1:0]    inflight_now;

    modport source (
        output valid, status, chunk_kind, chunk_src, chunk_dst, chunk_len, last_chunk,
               inflight_now,
        input  ready
    );
    modport sink (
        input  valid, status, chunk_kind, chunk_src, chunk_dst, chunk_len, last_chunk,
               inflight_now,
        output ready
    );
endinterface

interface sdcg_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [sdcg_pkg::CFG_IDX_W-1:0]    index;
    logic [sdcg_pkg::CFG_DATA_W-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink (input valid, index, data, output ready);
endinterface

[rtl/sdcg_out_buf.sv]
`include "strided_dma_chunk_generator_macros.svh"

module sdcg_out_buf #(
    parameter int WIDTH = 1
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_ready,
    output logic             o_valid,
    output logic [WIDTH-1:0] o_data,
    input  logic             i_out_ready
);

    logic             r_head_valid;
    logic             r_skid_valid;
    logic [WIDTH-1:0] r_head_data;
    logic [WIDTH-1:0] r_skid_data;
    logic             w_pop;

    assign w_pop   = r_head_valid & i_out_ready;
    assign o_ready = !r_skid_valid;
    assign o_valid = r_head_valid;
    assign o_data  = r_head_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head_valid <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_pop) begin
            r_head_valid <= r_skid_valid | i_push;
            r_skid_valid <= 1'b0;
        end else if (i_push) begin
            if (r_head_valid) begin
                r_skid_valid <= 1'b1;
            end else begin
                r_head_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_pop) begin
            r_head_data <= r_skid_valid ? r_skid_data : i_data;
        end else if (i_push && !r_head_valid) begin
            r_head_data <= i_data;
        end
        // park the beat while the head is stalled
        if (i_push && r_head_valid && !w_pop) begin
            r_skid_data <= i_data;
        end
    end

    `SDCG_ASSERT(a_skid_needs_head, i_clk, i_rst_n, r_skid_valid |-> r_head_valid, "skid holds a beat behind an empty head")
    `SDCG_ASSERT(a_stall_fills_skid, i_clk, i_rst_n, i_push && r_head_valid && !w_pop |=> r_skid_valid, "stalled push was lost")
    `SDCG_ASSERT(a_drain_empties, i_clk, i_rst_n, w_pop && !r_skid_valid && !i_push |=> !r_head_valid, "head stays valid after last beat left")

endmodule

[rtl/strided_dma_chunk_generator.sv]
// Two-dimensional strided DMA chunk generator.
//
// i_in carries one op per beat: load a descriptor, step, or a remote chunk
// completion. Every accepted beat yields exactly one result beat on o_out,
// carrying a status code, the chunk fields (zero unless a chunk went out)
// and the remote in-flight count after the op. i_cfg writes flit_bytes (0),
// max_inflight (1) and setup_steps (2); it is always ready and is meant to
// be written only while no descriptor is active.
//
// Each result beat is registered in the output buffer. i_in takes one beat per
// cycle while the buffer has room: each op is resolved in a single pass against the walker
// state, and row start addresses advance by one stride add per row.
// A two-entry output buffer keeps i_in open while one result waits; with a
// stalled receiver, i_in drops ready once both entries are full.
//
// Synchronous active-low reset clears the walker, the in-flight count and
// the output buffer, and loads the configuration defaults (64, 16, 0).
`include "strided_dma_chunk_generator_macros.svh"

module strided_dma_chunk_generator #(
    parameter int ADDR_WIDTH     = sdcg_pkg::DEF_ADDR_WIDTH,
    parameter int MAX_FLIT_BYTES = sdcg_pkg::DEF_MAX_FLIT_BYTES
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    sdcg_in_if.sink       i_in,
    sdcg_out_if.source    o_out,
    sdcg_cfg_if.sink      i_cfg
);

    localparam int FLW   = $clog2(MAX_FLIT_BYTES + 1);
    localparam int CMP_W = (FLW > sdcg_pkg::FLIT_CFG_W) ? FLW : sdcg_pkg::FLIT_CFG_W;
    localparam int RES_W = sdcg_pkg::STATUS_W + sdcg_pkg::KIND_W + 2 * ADDR_WIDTH + FLW + 1
                         + sdcg_pkg::COUNT_W;

    // configuration
    logic [sdcg_pkg::FLIT_CFG_W-1:0] r_flit_cfg;
    logic [sdcg_pkg::COUNT_W-1:0]    r_max_inflight;
    logic [sdcg_pkg::COUNT_W-1:0]    r_setup_steps;

    // walker state
    logic                             r_busy;
    logic [sdcg_pkg::COUNT_W-1:0]     r_setup_left;
    logic [ADDR_WIDTH-1:0]            r_src_row;
    logic [ADDR_WIDTH-1:0]            r_dst_row;
    logic [sdcg_pkg::ROW_W-1:0]       r_rows_total;
    logic [sdcg_pkg::ROW_W-1:0]       r_row_size;
    logic signed [sdcg_pkg::STRIDE_W-1:0] r_src_stride;
    logic signed [sdcg_pkg::STRIDE_W-1:0] r_dst_stride;
    logic                             r_src_dram;
    logic                             r_dst_dram;
    logic                             r_src_own;
    logic                             r_dst_own;
    logic [sdcg_pkg::ROW_W-1:0]       r_row_index;
    logic [sdcg_pkg::ROW_W-1:0]       r_row_offset;
    logic [sdcg_pkg::COUNT_W-1:0]     r_inflight;

    logic                             n_busy;
    logic [sdcg_pkg::COUNT_W-1:0]     n_setup_left;
    logic [ADDR_WIDTH-1:0]            n_src_row;
    logic [ADDR_WIDTH-1:0]            n_dst_row;
    logic [sdcg_pkg::ROW_W-1:0]       n_row_index;
    logic [sdcg_pkg::ROW_W-1:0]       n_row_offset;
    logic [sdcg_pkg::COUNT_W-1:0]     n_inflight;
    logic                             n_load;

    // chunk datapath
    logic [CMP_W-1:0]                 w_flit_capped;
    logic [FLW-1:0]                   w_flit;
    logic [FLW-1:0]                   w_flit_mask;
    logic [ADDR_WIDTH-1:0]            w_src;
    logic [ADDR_WIDTH-1:0]            w_dst;
    logic [sdcg_pkg::ROW_W-1:0]       w_remain;
    logic [FLW-1:0]                   w_len_row;
    logic [FLW-1:0]                   w_src_room;
    logic [FLW-1:0]                   w_dst_room;
    logic [FLW-1:0]                   w_len_src;
    logic [FLW-1:0]                   w_len;
    logic [sdcg_pkg::ROW_W-1:0]       w_off_next;
    logic [sdcg_pkg::ROW_W-1:0]       w_idx_next;
    logic                             w_row_done;
    sdcg_pkg::t_kind                  w_kind;
    logic                             w_stall;

    // result
    sdcg_pkg::t_status                w_res_status;
    sdcg_pkg::t_kind                  w_res_kind;
    logic [ADDR_WIDTH-1:0]            w_res_src;
    logic [ADDR_WIDTH-1:0]            w_res_dst;
    logic [FLW-1:0]                   w_res_len;
    logic                             w_res_last;
    logic [RES_W-1:0]                 w_res_data;
    logic [RES_W-1:0]                 w_out_data;

    logic                             w_accept;
    logic                             w_in_ready;

    assign i_cfg.ready = 1'b1;
    assign i_in.ready  = w_in_ready;
    assign w_accept    = i_in.valid & w_in_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flit_cfg     <= sdcg_pkg::FLIT_RESET;
            r_max_inflight <= sdcg_pkg::INFLIGHT_RESET;
            r_setup_steps  <= sdcg_pkg::SETUP_RESET;
        end else if (i_cfg.valid) begin
            unique case (sdcg_pkg::t_cfg_idx'(i_cfg.index))
                sdcg_pkg::CFG_FLIT_BYTES:   r_flit_cfg     <= i_cfg.data[sdcg_pkg::FLIT_CFG_W-1:0];
                sdcg_pkg::CFG_MAX_INFLIGHT: r_max_inflight <= i_cfg.data;
                sdcg_pkg::CFG_SETUP_STEPS:  r_setup_steps  <= i_cfg.data;
                default: ;
            endcase
        end
    end

    // flit size: clamp to the maximum, then round down to a power of two
    always_comb begin
        w_flit_capped = (CMP_W'(r_flit_cfg) > CMP_W'(MAX_FLIT_BYTES))
                      ? CMP_W'(MAX_FLIT_BYTES) : CMP_W'(r_flit_cfg);
        w_flit = FLW'(1);
        for (int i = 0; i < CMP_W; i++) begin
            if (w_flit_capped[i]) begin
                w_flit = FLW'(1) << i;
            end
        end
    end

    assign w_flit_mask = w_flit - FLW'(1);
    assign w_src       = r_src_row + ADDR_WIDTH'(r_row_offset);
    assign w_dst       = r_dst_row + ADDR_WIDTH'(r_row_offset);
    assign w_remain    = r_row_size - r_row_offset;
    assign w_len_row   = (w_remain > sdcg_pkg::ROW_W'(w_flit)) ? w_flit : w_remain[FLW-1:0];
    assign w_src_room  = w_flit - (w_src[FLW-1:0] & w_flit_mask);
    assign w_dst_room  = w_flit - (w_dst[FLW-1:0] & w_flit_mask);
    assign w_len_src   = (r_src_dram && w_src_room < w_len_row) ? w_src_room : w_len_row;
    assign w_len       = (r_dst_dram && w_dst_room < w_len_src) ? w_dst_room : w_len_src;
    assign w_off_next  = r_row_offset + sdcg_pkg::ROW_W'(w_len);
    assign w_idx_next  = r_row_index + sdcg_pkg::ROW_W'(1);
    assign w_row_done  = (w_off_next == r_row_size);

    always_comb begin
        if (r_src_own && r_dst_own) begin
            w_kind = sdcg_pkg::KIND_LOCAL;
        end else if (r_src_own) begin
            w_kind = sdcg_pkg::KIND_PUSH;
        end else begin
            w_kind = sdcg_pkg::KIND_PULL;
        end
    end

    assign w_stall = (w_kind != sdcg_pkg::KIND_LOCAL) && (r_inflight >= r_max_inflight);

    always_comb begin
        n_busy       = r_busy;
        n_setup_left = r_setup_left;
        n_src_row    = r_src_row;
        n_dst_row    = r_dst_row;
        n_row_index  = r_row_index;
        n_row_offset = r_row_offset;
        n_inflight   = r_inflight;
        n_load       = 1'b0;
        w_res_status = sdcg_pkg::ST_IDLE;
        w_res_kind   = sdcg_pkg::KIND_LOCAL;
        w_res_src    = '0;
        w_res_dst    = '0;
        w_res_len    = '0;
        w_res_last   = 1'b0;
        unique case (sdcg_pkg::t_op'(i_in.op))
            sdcg_pkg::OP_LOAD: begin
                if (r_busy) begin
                    w_res_status = sdcg_pkg::ST_BUSY;
                end else if (i_in.row_count == '0 || i_in.row_length == '0) begin
                    w_res_status = sdcg_pkg::ST_EMPTY;
                end else if (!i_in.src_is_own && !i_in.dst_is_own) begin
                    w_res_status = sdcg_pkg::ST_NO_LOCAL;
                end else begin
                    n_load       = 1'b1;
                    n_busy       = 1'b1;
                    n_setup_left = r_setup_steps;
                    n_src_row    = i_in.src_base;
                    n_dst_row    = i_in.dst_base;
                    n_row_index  = '0;
                    n_row_offset = '0;
                    w_res_status = sdcg_pkg::ST_LOADED;
                end
            end
            sdcg_pkg::OP_STEP: begin
                if (!r_busy) begin
                    w_res_status = sdcg_pkg::ST_IDLE;
                end else if (r_setup_left != '0) begin
                    n_setup_left = r_setup_left - sdcg_pkg::COUNT_W'(1);
                    w_res_status = sdcg_pkg::ST_SETUP;
                end else if (w_stall) begin
                    w_res_status = sdcg_pkg::ST_STALL;
                end else begin
                    if (w_kind != sdcg_pkg::KIND_LOCAL) begin
                        n_inflight = r_inflight + sdcg_pkg::COUNT_W'(1);
                    end
                    if (w_row_done) begin
                        // advance to the next row start
                        n_row_offset = '0;
                        n_row_index  = w_idx_next;
                        n_src_row    = r_src_row + ADDR_WIDTH'(r_src_stride);
                        n_dst_row    = r_dst_row + ADDR_WIDTH'(r_dst_stride);
                        if (w_idx_next == r_rows_total) begin
                            w_res_last = 1'b1;
                            n_busy     = 1'b0;
                        end
                    end else begin
                        n_row_offset = w_off_next;
                    end
                    w_res_status = sdcg_pkg::ST_CHUNK;
                    w_res_kind   = w_kind;
                    w_res_src    = w_src;
                    w_res_dst    = w_dst;
                    w_res_len    = w_len;
                end
            end
            sdcg_pkg::OP_DONE: begin
                if (r_inflight == '0) begin
                    w_res_status = sdcg_pkg::ST_UNDERFLOW;
                end else begin
                    n_inflight   = r_inflight - sdcg_pkg::COUNT_W'(1);
                    w_res_status = sdcg_pkg::ST_DONE_OK;
                end
            end
            sdcg_pkg::OP_RSVD: begin
                w_res_status = sdcg_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy       <= 1'b0;
            r_setup_left <= '0;
            r_row_index  <= '0;
            r_row_offset <= '0;
            r_inflight   <= '0;
        end else if (w_accept) begin
            r_busy       <= n_busy;
            r_setup_left <= n_setup_left;
            r_row_index  <= n_row_index;
            r_row_offset <= n_row_offset;
            r_inflight   <= n_inflight;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_src_row <= n_src_row;
            r_dst_row <= n_dst_row;
        end
        if (w_accept && n_load) begin
            r_rows_total <= i_in.row_count;
            r_row_size   <= i_in.row_length;
            r_src_stride <= i_in.src_step;
            r_dst_stride <= i_in.dst_step;
            r_src_dram   <= i_in.src_in_dram;
            r_dst_dram   <= i_in.dst_in_dram;
            r_src_own    <= i_in.src_is_own;
            r_dst_own    <= i_in.dst_is_own;
        end
    end

    assign w_res_data = {w_res_status, w_res_kind, w_res_src, w_res_dst, w_res_len, w_res_last,
                         n_inflight};

    sdcg_out_buf #(
        .WIDTH (RES_W)
    ) u_out_buf (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_accept),
        .i_data      (w_res_data),
        .o_ready     (w_in_ready),
        .o_valid     (o_out.valid),
        .o_data      (w_out_data),
        .i_out_ready (o_out.ready)
    );

    assign {o_out.status, o_out.chunk_kind, o_out.chunk_src, o_out.chunk_dst, o_out.chunk_len,
            o_out.last_chunk, o_out.inflight_now} = w_out_data;

    `SDCG_ASSERT(a_busy_ends_on_last, i_clk, i_rst_n, $fell(r_busy) |-> $past(w_accept && w_res_last), "descriptor ended without a last chunk")
    `SDCG_ASSERT(a_offset_in_row, i_clk, i_rst_n, r_busy |-> (r_row_offset < r_row_size), "row offset ran past the row")
    `SDCG_ASSERT(a_inflight_moves_on_beat, i_clk, i_rst_n, !$stable(r_inflight) |-> $past(w_accept), "in-flight count moved without a beat")

endmodule

[sim/strided_dma_chunk_generator_checker.sv]
module strided_dma_chunk_generator_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    sdcg_in_if         i_in,
    sdcg_out_if        i_out,
    sdcg_cfg_if        i_cfg,
    output int         o_errors,
    output int         o_pending,
    output logic       o_busy,
    output logic [7:0] o_inflight,
    output int         o_chunks,
    output int         o_stalls,
    output int         o_finished
);

    typedef struct packed {
        sdcg_pkg::t_status status;
        sdcg_pkg::t_kind   kind;
        logic [31:0]       src;
        logic [31:0]       dst;
        logic [6:0]        len;
        logic              last;
        logic [7:0]        inflight;
    } t_dma_result;

    // register copies
    logic [6:0]  flit_reg;
    logic [7:0]  inflight_cap;
    logic [7:0]  setup_reg;

    // walker copy
    logic        desc_active;
    logic [7:0]  setup_wait;
    logic [31:0] src_row0;
    logic [31:0] dst_row0;
    logic [15:0] n_rows;
    logic [15:0] row_span;
    logic [31:0] src_pitch;
    logic [31:0] dst_pitch;
    logic [3:0]  side_bits;
    logic [15:0] cur_row;
    logic [15:0] cur_col;
    logic [7:0]  remote_out;

    t_dma_result awaited_results[$];
    t_dma_result want;
    t_dma_result seen;

    assign o_busy     = desc_active;
    assign o_inflight = remote_out;

    function automatic int unsigned usable_flit(logic [6:0] f);
        int unsigned lim;
        int unsigned p;
        lim = (f > sdcg_pkg::DEF_MAX_FLIT_BYTES) ? sdcg_pkg::DEF_MAX_FLIT_BYTES : f;
        p = 1;
        while (2 * p <= lim) p = 2 * p;
        return p;
    endfunction

    // stop a chunk at the next flit boundary of its address
    function automatic int unsigned clip_to_flit(int unsigned n, logic [31:0] a,
                                                 int unsigned fl);
        int unsigned room;
        room = fl - (a & (fl - 1));
        return (n < room) ? n : room;
    endfunction

    function automatic t_dma_result advance_walker(
        sdcg_pkg::t_op op, logic [31:0] sb, logic [31:0] db, logic [15:0] nr,
        logic [15:0] nl, logic [31:0] ss, logic [31:0] ds, logic [3:0] sides);
        t_dma_result     r;
        logic [31:0]     sa;
        logic [31:0]     da;
        int unsigned     fl;
        int unsigned     n;
        sdcg_pkg::t_kind k;
        r = '0;
        r.status = sdcg_pkg::ST_IDLE;
        r.kind = sdcg_pkg::KIND_LOCAL;
        case (op)
            sdcg_pkg::OP_LOAD: begin
                if (desc_active) begin
                    r.status = sdcg_pkg::ST_BUSY;
                end else if (nr == 0 || nl == 0) begin
                    r.status = sdcg_pkg::ST_EMPTY;
                end else if (sides[3:2] == 2'b00) begin
                    r.status = sdcg_pkg::ST_NO_LOCAL;
                end else begin
                    src_row0 = sb;
                    dst_row0 = db;
                    n_rows = nr;
                    row_span = nl;
                    src_pitch = ss;
                    dst_pitch = ds;
                    side_bits = sides;
                    cur_row = '0;
                    cur_col = '0;
                    setup_wait = setup_reg;
                    desc_active = 1'b1;
                    r.status = sdcg_pkg::ST_LOADED;
                end
            end
            sdcg_pkg::OP_STEP: begin
                if (!desc_active) begin
                    r.status = sdcg_pkg::ST_IDLE;
                end else if (setup_wait != 0) begin
                    setup_wait = setup_wait - 1'b1;
                    r.status = sdcg_pkg::ST_SETUP;
                end else begin
                    fl = usable_flit(flit_reg);
                    sa = src_row0 + {16'd0, cur_row} * src_pitch + {16'd0, cur_col};
                    da = dst_row0 + {16'd0, cur_row} * dst_pitch + {16'd0, cur_col};
                    n = row_span - cur_col;
                    if (n > fl) n = fl;
                    if (side_bits[0]) n = clip_to_flit(n, sa, fl);
                    if (side_bits[1]) n = clip_to_flit(n, da, fl);
                    if (side_bits[2] && side_bits[3]) k = sdcg_pkg::KIND_LOCAL;
                    else if (side_bits[2]) k = sdcg_pkg::KIND_PUSH;
                    else k = sdcg_pkg::KIND_PULL;
                    if (k != sdcg_pkg::KIND_LOCAL && remote_out >= inflight_cap) begin
                        r.status = sdcg_pkg::ST_STALL;
                    end else begin
                        if (k != sdcg_pkg::KIND_LOCAL) remote_out = remote_out + 1'b1;
                        if (32'(cur_col) + n >= 32'(row_span)) begin
                            cur_col = '0;
                            cur_row = cur_row + 1'b1;
                        end else begin
                            cur_col = cur_col + 16'(n);
                        end
                        if (cur_row >= n_rows) begin
                            r.last = 1'b1;
                            desc_active = 1'b0;
                        end
                        r.status = sdcg_pkg::ST_CHUNK;
                        r.kind = k;
                        r.src = sa;
                        r.dst = da;
                        r.len = 7'(n);
                    end
                end
            end
            sdcg_pkg::OP_DONE: begin
                if (remote_out == 0) begin
                    r.status = sdcg_pkg::ST_UNDERFLOW;
                end else begin
                    remote_out = remote_out - 1'b1;
                    r.status = sdcg_pkg::ST_DONE_OK;
                end
            end
            default: ;
        endcase
        r.inflight = remote_out;
        return r;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            flit_reg = sdcg_pkg::FLIT_RESET;
            inflight_cap = sdcg_pkg::INFLIGHT_RESET;
            setup_reg = sdcg_pkg::SETUP_RESET;
            desc_active = 1'b0;
            setup_wait = '0;
            src_row0 = '0;
            dst_row0 = '0;
            n_rows = '0;
            row_span = '0;
            src_pitch = '0;
            dst_pitch = '0;
            side_bits = '0;
            cur_row = '0;
            cur_col = '0;
            remote_out = '0;
            awaited_results.delete();
            o_errors = 0;
            o_chunks = 0;
            o_stalls = 0;
            o_finished = 0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (sdcg_pkg::t_cfg_idx'(i_cfg.index))
                    sdcg_pkg::CFG_FLIT_BYTES:   flit_reg = i_cfg.data[6:0];
                    sdcg_pkg::CFG_MAX_INFLIGHT: inflight_cap = i_cfg.data;
                    sdcg_pkg::CFG_SETUP_STEPS:  setup_reg = i_cfg.data;
                    default: ;
                endcase
            end
            if (i_in.valid && i_in.ready) begin
                want = advance_walker(sdcg_pkg::t_op'(i_in.op), i_in.src_base, i_in.dst_base,
                                      i_in.row_count, i_in.row_length, i_in.src_step,
                                      i_in.dst_step,
                                      {i_in.dst_is_own, i_in.src_is_own,
                                       i_in.dst_in_dram, i_in.src_in_dram});
                if (want.status == sdcg_pkg::ST_CHUNK) o_chunks++;
                if (want.status == sdcg_pkg::ST_STALL) o_stalls++;
                if (want.last) o_finished++;
                awaited_results.insert(awaited_results.size(), want);
            end
            if (i_out.valid && i_out.ready) begin
                seen.status = sdcg_pkg::t_status'(i_out.status);
                seen.kind = sdcg_pkg::t_kind'(i_out.chunk_kind);
                seen.src = i_out.chunk_src;
                seen.dst = i_out.chunk_dst;
                seen.len = i_out.chunk_len;
                seen.last = i_out.last_chunk;
                seen.inflight = i_out.inflight_now;
                if (awaited_results.size() == 0) begin
                    o_errors++;
                    if (o_errors <= 10)
                        $display("unexpected result beat: status %0d", seen.status);
                end else begin
                    want = awaited_results[0];
                    awaited_results.delete(0);
                    if (seen.status !== want.status || seen.kind !== want.kind ||
                        seen.src !== want.src || seen.dst !== want.dst ||
                        seen.len !== want.len || seen.last !== want.last ||
                        seen.inflight !== want.inflight) begin
                        o_errors++;
                        if (o_errors <= 10)
                            $display({"mismatch (exp/got): status %0d/%0d kind %0d/%0d ",
                                      "src %h/%h dst %h/%h len %0d/%0d last %0d/%0d ",
                                      "inflight %0d/%0d"},
                                     want.status, seen.status, want.kind, seen.kind,
                                     want.src, seen.src, want.dst, seen.dst,
                                     want.len, seen.len, want.last, seen.last,
                                     want.inflight, seen.inflight);
                    end
                end
            end
        end
        o_pending = awaited_results.size();
    end

endmodule

[sim/strided_dma_chunk_generator_tb.sv]
module strided_dma_chunk_generator_tb;

    localparam int QUIET_LIMIT = 2000;

    typedef struct {
        sdcg_pkg::t_op op;
        logic [31:0]   src_base;
        logic [31:0]   dst_base;
        logic [15:0]   rows;
        logic [15:0]   row_len;
        logic [31:0]   src_step;
        logic [31:0]   dst_step;
        logic [3:0]    sides;     // dst_own, src_own, dst_dram, src_dram
    } t_dma_beat;

    logic       i_clk;
    logic       i_rst_n;
    int         gap_pct;
    int         stall_pct;
    int         flit_hint;
    int         beats_sent;

    int         chk_errors;
    int         chk_pending;
    logic       chk_busy;
    logic [7:0] chk_inflight;
    int         chk_chunks;
    int         chk_stalls;
    int         chk_finished;

    sdcg_in_if  in_if ();
    sdcg_out_if out_if ();
    sdcg_cfg_if cfg_if ();

    strided_dma_chunk_generator dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    strided_dma_chunk_generator_checker chunk_check (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (in_if),
        .i_out      (out_if),
        .i_cfg      (cfg_if),
        .o_errors   (chk_errors),
        .o_pending  (chk_pending),
        .o_busy     (chk_busy),
        .o_inflight (chk_inflight),
        .o_chunks   (chk_chunks),
        .o_stalls   (chk_stalls),
        .o_finished (chk_finished)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        out_if.ready <= ($urandom_range(99) >= stall_pct);
    end

    initial begin : watchdog
        int quiet;
        quiet = 0;
        while (quiet < QUIET_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
                (cfg_if.valid && cfg_if.ready))
                quiet = 0;
            else
                quiet++;
        end
        $display("timeout: no beat moved for %0d cycles", QUIET_LIMIT);
        $display("DONE: errors detected");
        $finish;
    end

    function automatic t_dma_beat rand_beat(sdcg_pkg::t_op op);
        t_dma_beat b;
        b.op = op;
        b.src_base = $urandom;
        b.dst_base = $urandom;
        b.rows = 16'($urandom);
        b.row_len = 16'($urandom);
        b.src_step = $urandom;
        b.dst_step = $urandom;
        b.sides = 4'($urandom);
        return b;
    endfunction

    function automatic t_dma_beat make_load(logic [31:0] sb, logic [31:0] db,
                                            logic [15:0] nr, logic [15:0] nl,
                                            logic [31:0] ss, logic [31:0] ds,
                                            logic [3:0] sides);
        t_dma_beat b;
        b.op = sdcg_pkg::OP_LOAD;
        b.src_base = sb;
        b.dst_base = db;
        b.rows = nr;
        b.row_len = nl;
        b.src_step = ss;
        b.dst_step = ds;
        b.sides = sides;
        return b;
    endfunction

    // Enter and leave at a falling edge; valid stays up into the next beat.
    task automatic send_beat(input t_dma_beat b);
        while ($urandom_range(99) < gap_pct) begin
            in_if.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_if.op          <= b.op;
        in_if.src_base    <= b.src_base;
        in_if.dst_base    <= b.dst_base;
        in_if.row_count   <= b.rows;
        in_if.row_length  <= b.row_len;
        in_if.src_step    <= b.src_step;
        in_if.dst_step    <= b.dst_step;
        in_if.src_in_dram <= b.sides[0];
        in_if.dst_in_dram <= b.sides[1];
        in_if.src_is_own  <= b.sides[2];
        in_if.dst_is_own  <= b.sides[3];
        in_if.valid       <= 1'b1;
        do @(posedge i_clk); while (in_if.ready !== 1'b1);
        @(negedge i_clk);
        beats_sent++;
    endtask

    task automatic send_op(input sdcg_pkg::t_op op);
        send_beat(rand_beat(op));
    endtask

    task automatic walk_to_end();
        while (chk_busy) send_op(sdcg_pkg::OP_STEP);
    endtask

    // Hold the sender until every result is back.
    task automatic settle();
        in_if.valid <= 1'b0;
        @(negedge i_clk);
        while (chk_pending != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input sdcg_pkg::t_cfg_idx idx, input logic [7:0] d,
                             input bit more);
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= d;
        do @(posedge i_clk); while (cfg_if.ready !== 1'b1);
        @(negedge i_clk);
        if (!more) cfg_if.valid <= 1'b0;
    endtask

    task automatic program_regs(input logic [7:0] flit_d, input logic [7:0] cap_d,
                                input logic [7:0] setup_d, input bit poke_unused);
        write_reg(sdcg_pkg::CFG_FLIT_BYTES, flit_d, 1'b1);
        write_reg(sdcg_pkg::CFG_MAX_INFLIGHT, cap_d, 1'b1);
        write_reg(sdcg_pkg::CFG_SETUP_STEPS, setup_d, poke_unused);
        if (poke_unused) write_reg(sdcg_pkg::CFG_UNUSED, 8'($urandom), 1'b0);
        flit_hint = flit_d[6:0];
        if (flit_hint > sdcg_pkg::DEF_MAX_FLIT_BYTES) flit_hint = sdcg_pkg::DEF_MAX_FLIT_BYTES;
        if (flit_hint == 0) flit_hint = 1;
    endtask

    task automatic send_rejected_load();
        t_dma_beat b;
        b = rand_beat(sdcg_pkg::OP_LOAD);
        case ($urandom_range(2))
            0:       b.rows = '0;
            1:       b.row_len = '0;
            default: b.sides[3:2] = 2'b00;
        endcase
        send_beat(b);
    endtask

    task automatic run_descriptor(input int walk_limit, input bit allow_remote);
        t_dma_beat d;
        int        n;
        d = rand_beat(sdcg_pkg::OP_LOAD);
        d.rows = ($urandom_range(9) == 0) ? 16'($urandom_range(5, 12))
                                          : 16'($urandom_range(1, 4));
        d.row_len = 16'($urandom_range(1, 3 * flit_hint + 8));
        case ($urandom_range(2))
            0: d.src_base = {24'hFFFFFF, 8'($urandom)};
            1: d.src_base = {24'h0, 8'($urandom)};
            default: ;
        endcase
        case ($urandom_range(2))
            0: d.dst_base = {24'hFFFFFF, 8'($urandom)};
            1: d.dst_base = {24'h0, 8'($urandom)};
            default: ;
        endcase
        case ($urandom_range(3))
            0: d.src_step = 32'($urandom_range(512)) - 32'd256;
            1: d.src_step = 32'(flit_hint * $urandom_range(8));
            2: d.src_step = '0;
            default: ;
        endcase
        case ($urandom_range(3))
            0: d.dst_step = 32'($urandom_range(512)) - 32'd256;
            1: d.dst_step = -32'(flit_hint * $urandom_range(8));
            2: d.dst_step = '0;
            default: ;
        endcase
        if (!allow_remote)
            d.sides[3:2] = 2'b11;
        else
            case ($urandom_range(2))
                0: d.sides[3:2] = 2'b01;
                1: d.sides[3:2] = 2'b10;
                default: d.sides[3:2] = 2'b11;
            endcase
        send_beat(d);
        n = 0;
        while (chk_busy && n < walk_limit) begin
            if ($urandom_range(99) < 4)
                send_op(sdcg_pkg::OP_LOAD);
            else if (chk_inflight != 0 && $urandom_range(99) < 35)
                send_op(sdcg_pkg::OP_DONE);
            else
                send_op(sdcg_pkg::OP_STEP);
            n++;
        end
    endtask

    task automatic run_phase(input int budget, input bit allow_remote);
        int stop;
        stop = beats_sent + budget;
        while (beats_sent < stop) begin
            if ($urandom_range(3) == 0) send_rejected_load();
            if ($urandom_range(9) == 0) send_op(sdcg_pkg::OP_RSVD);
            run_descriptor(100000, allow_remote);
            if ($urandom_range(2) == 0) send_op(sdcg_pkg::OP_DONE);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        gap_pct = 20;
        stall_pct = 20;
        flit_hint = sdcg_pkg::DEF_MAX_FLIT_BYTES;
        beats_sent = 0;
        in_if.valid = 1'b0;
        in_if.op = sdcg_pkg::OP_STEP;
        in_if.src_base = '0;
        in_if.dst_base = '0;
        in_if.row_count = '0;
        in_if.row_length = '0;
        in_if.src_step = '0;
        in_if.dst_step = '0;
        in_if.src_in_dram = 1'b0;
        in_if.dst_in_dram = 1'b0;
        in_if.src_is_own = 1'b0;
        in_if.dst_is_own = 1'b0;
        cfg_if.valid = 1'b0;
        cfg_if.index = sdcg_pkg::CFG_FLIT_BYTES;
        cfg_if.data = '0;
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset defaults: idle step, underflow, reserved op, rejected loads
        send_op(sdcg_pkg::OP_STEP);
        send_op(sdcg_pkg::OP_DONE);
        send_op(sdcg_pkg::OP_RSVD);
        send_beat(make_load('1, '1, 16'd0, 16'hFFFF, '1, '1, 4'b1111));
        send_beat(make_load('0, '0, 16'hFFFF, 16'd0, '0, '0, 4'b0000));
        send_beat(make_load($urandom, $urandom, 16'd1, 16'd1, '0, '0, 4'b0011));
        // push across the address wrap with both sides in DRAM, load while busy
        send_beat(make_load(32'hFFFF_FFF0, 32'h0000_0005, 16'd2, 16'd100,
                            32'h8000_0000, 32'h7FFF_FFFF, 4'b0111));
        send_op(sdcg_pkg::OP_STEP);
        send_beat(make_load('1, '1, 16'd1, 16'd1, '1, '1, 4'b1111));
        walk_to_end();
        repeat (3) send_op(sdcg_pkg::OP_DONE);
        // pull, then a local copy with a negative stride
        send_beat(make_load('0, 32'hFFFF_FFFF, 16'd1, 16'd1, '0, '0, 4'b1000));
        walk_to_end();
        send_beat(make_load(32'h1000, 32'h2000, 16'd3, 16'd5, 32'hFFFF_FFFB,
                            32'h0000_0040, 4'b1111));
        walk_to_end();
        run_phase(200, 1'b1);

        settle();
        program_regs(8'h81, 8'd1, 8'd0, 1'b0);
        run_phase(150, 1'b1);

        // no idling on either side for this stretch
        settle();
        program_regs(8'h40, 8'd255, 8'd3, 1'b1);
        gap_pct = 0;
        stall_pct = 0;
        run_phase(200, 1'b1);
        gap_pct = 20;
        stall_pct = 20;

        settle();
        program_regs(8'h07, 8'd2, 8'd1, 1'b0);
        run_phase(160, 1'b1);

        settle();
        program_regs(8'hFF, 8'd4, 8'd255, 1'b0);
        run_phase(100, 1'b1);

        settle();
        program_regs(8'h80, 8'd3, 8'd2, 1'b0);
        run_phase(120, 1'b1);

        // zero cap: local copies still run, the final remote descriptor never gets out
        settle();
        program_regs(8'h20, 8'd0, 8'd0, 1'b0);
        run_phase(120, 1'b0);
        send_beat(make_load($urandom, $urandom, 16'hFFFF, 16'hFFFF, $urandom, $urandom,
                            4'b1001));
        repeat (6) begin
            send_op(sdcg_pkg::OP_STEP);
            send_op(sdcg_pkg::OP_DONE);
        end

        settle();
        repeat (8) @(posedge i_clk);
        $display("covered %0d beats over seven register settings (odd, zero, oversize flit;",
                 beats_sent);
        $display("caps 0..255; setup 0..255): %0d chunks, %0d stalls, %0d descriptors done",
                 chk_chunks, chk_stalls, chk_finished);
        if (chk_errors == 0 && chk_pending == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
